/* rtl/hbq_pkg.sv */
// ----------------------------------------------------------------------------
// hbq_pkg
// Shared types, codes and the sequencer control store of the binary min-heap
// priority queue.
// ----------------------------------------------------------------------------
package hbq_pkg;

	localparam int HEAP_CAPACITY = 64;
	localparam int KEY_W         = 16;
	localparam int PAY_W         = 16;
	localparam int FILL_W        = 7;
	localparam int STATUS_W      = 2;

	localparam logic FUNC_INSERT  = 1'b0;
	localparam logic FUNC_EXTRACT = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic             func;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} req_t;

	typedef struct packed {
		logic [PAY_W-1:0]    out_payload;
		logic [KEY_W-1:0]    out_key;
		logic                out_valid;
		logic [STATUS_W-1:0] status;
		logic [FILL_W-1:0]   fill_level;
	} rsp_t;

	// one heap slot: key in the upper half, payload in the lower half
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// microcode step addresses
	typedef enum logic [3:0] {
		S_IDLE,
		S_I_UP,
		S_I_CMP,
		S_PUT,
		S_E_ROOT,
		S_E_LAST,
		S_E_MOV,
		S_D_LEFT,
		S_D_RIGHT,
		S_D_PICK,
		S_D_SINK,
		S_FIN
	} step_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_PARENT,
		RD_ROOT,
		RD_LAST,
		RD_LEFT,
		RD_RIGHT
	} rd_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_PARENT,
		WR_CHILD,
		WR_MOV
	} wr_t;

	typedef enum logic [2:0] {
		CAP_NONE,
		CAP_TOP,
		CAP_MOV,
		CAP_LEFT,
		CAP_RIGHT
	} cap_t;

	typedef enum logic [1:0] {
		POS_HOLD,
		POS_PARENT,
		POS_CHILD
	} posop_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ROOT,
		C_NOT_GT,
		C_NO_LEFT,
		C_NO_RIGHT,
		C_NOT_SINK
	} cond_t;

	// When cond holds the step jumps to tgt and skips rd, wr, pos and dec;
	// otherwise it performs them and goes to nxt. cap is always performed.
	typedef struct packed {
		cond_t  cond;
		step_t  tgt;
		step_t  nxt;
		rd_t    rd;
		wr_t    wr;
		cap_t   cap;
		posop_t pos;
		logic   dec;
		logic   fin;
	} ctl_t;

	function automatic ctl_t ucode(input step_t s);
		ctl_t c;
		c = '{cond: C_NEVER, tgt: S_IDLE, nxt: S_IDLE, rd: RD_NONE, wr: WR_NONE,
			cap: CAP_NONE, pos: POS_HOLD, dec: 1'b0, fin: 1'b0};
		case (s)
			S_I_UP: begin
				c.cond = C_ROOT;  c.tgt = S_PUT; c.nxt = S_I_CMP; c.rd = RD_PARENT;
			end
			S_I_CMP: begin
				c.cond = C_NOT_GT; c.tgt = S_PUT; c.nxt = S_I_UP;
				c.wr = WR_PARENT;  c.pos = POS_PARENT;
			end
			S_PUT: begin
				c.nxt = S_FIN; c.wr = WR_MOV;
			end
			S_E_ROOT: begin
				c.nxt = S_E_LAST; c.rd = RD_ROOT;
			end
			S_E_LAST: begin
				c.nxt = S_E_MOV; c.rd = RD_LAST; c.cap = CAP_TOP;
			end
			S_E_MOV: begin
				c.nxt = S_D_LEFT; c.cap = CAP_MOV; c.dec = 1'b1;
			end
			S_D_LEFT: begin
				c.cond = C_NO_LEFT; c.tgt = S_PUT; c.nxt = S_D_RIGHT; c.rd = RD_LEFT;
			end
			S_D_RIGHT: begin
				c.cond = C_NO_RIGHT; c.tgt = S_D_SINK; c.nxt = S_D_PICK;
				c.rd = RD_RIGHT;     c.cap = CAP_LEFT;
			end
			S_D_PICK: begin
				c.nxt = S_D_SINK; c.cap = CAP_RIGHT;
			end
			S_D_SINK: begin
				c.cond = C_NOT_SINK; c.tgt = S_PUT; c.nxt = S_D_LEFT;
				c.wr = WR_CHILD;     c.pos = POS_CHILD;
			end
			S_FIN: begin
				c.fin = 1'b1;
			end
			default: ;
		endcase
		return c;
	endfunction

endpackage

/* rtl/hbq_ram.sv */
// ----------------------------------------------------------------------------
// hbq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hbq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/binary_min_heap_queue_core.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// Min-heap priority queue run by a microcoded sequencer over one heap RAM.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_valid / req_ready | hbq_pkg::req_t (func, key, payload)
//  rsp     | out | rsp_valid / rsp_ready | hbq_pkg::rsp_t (one per request)
//
// The sequencer returns to its idle step after each response before it
// takes the next request.
// Insert walks up one level per S_I_UP and S_I_CMP pair, stopping at the
// root or below it, and then writes the new entry in S_PUT.
// Extract walks down one level at a time; one RAM read per cycle sets the
// pace: the two children are fetched one after the other.
// Dropped inserts and extracts on an empty heap go straight to the final step.
// Reset clears the entry count; the heap RAM needs no clearing.
// A new request is taken once the previous one has reached the response
// register; a stalled response holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core #(
	parameter int CAPACITY = hbq_pkg::HEAP_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  hbq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output hbq_pkg::rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int FW = hbq_pkg::FILL_W;

	hbq_pkg::step_t  upc_q, upc_d, start_step;
	hbq_pkg::ctl_t   ctl;
	hbq_pkg::entry_t rd_ent, mov_q, top_q, child_q, wr_ent;
	hbq_pkg::rsp_t   rsp_q;

	logic [CW-1:0]                pos_q, cidx_q, cnt_q, par_idx;
	logic [CW:0]                  pos2;
	logic [AW-1:0]                raddr, waddr;
	logic [hbq_pkg::ENTRY_W-1:0]  rd_data;
	logic [hbq_pkg::STATUS_W-1:0] status_q;
	logic                         ext_q, rsp_vld_q;
	logic                         acc, full, empty, taken, act, re, we, fin_go;

	assign req_ready = (upc_q == hbq_pkg::S_IDLE);
	assign acc       = req_valid && req_ready;
	assign full      = (cnt_q == CW'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign ctl       = hbq_pkg::ucode(upc_q);
	assign rd_ent    = hbq_pkg::entry_t'(rd_data);
	assign pos2      = {pos_q, 1'b0};
	assign par_idx   = pos_q >> 1;
	assign fin_go    = ctl.fin && (!rsp_vld_q || rsp_ready);

	// branch condition
	always_comb begin
		case (ctl.cond)
			hbq_pkg::C_ROOT:     taken = (pos_q == CW'(1));
			hbq_pkg::C_NOT_GT:   taken = !(rd_ent.key > mov_q.key);
			hbq_pkg::C_NO_LEFT:  taken = (pos2 > {1'b0, cnt_q});
			hbq_pkg::C_NO_RIGHT: taken = (pos2 == {1'b0, cnt_q});
			hbq_pkg::C_NOT_SINK: taken = !(mov_q.key > child_q.key);
			default:             taken = 1'b0;
		endcase
	end

	assign act = !taken;

	// RAM address and write data (slot n lives at address n-1)
	always_comb begin
		case (ctl.rd)
			hbq_pkg::RD_PARENT: raddr = AW'(par_idx - CW'(1));
			hbq_pkg::RD_LAST:   raddr = AW'(cnt_q - CW'(1));
			hbq_pkg::RD_LEFT:   raddr = AW'(pos2 - (CW+1)'(1));
			hbq_pkg::RD_RIGHT:  raddr = AW'(pos2);
			default:            raddr = '0;
		endcase
		case (ctl.wr)
			hbq_pkg::WR_PARENT: wr_ent = rd_ent;
			hbq_pkg::WR_CHILD:  wr_ent = child_q;
			default:            wr_ent = mov_q;
		endcase
	end

	assign waddr = AW'(pos_q - CW'(1));
	assign re    = act && (ctl.rd != hbq_pkg::RD_NONE);
	assign we    = act && (ctl.wr != hbq_pkg::WR_NONE);

	hbq_ram #(
		.WIDTH(hbq_pkg::ENTRY_W),
		.DEPTH(CAPACITY)
	) u_heap (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_ent),
		.re   (re),
		.raddr(raddr),
		.rdata(rd_data)
	);

	// sequencer next step
	always_comb begin
		if (req.func == hbq_pkg::FUNC_INSERT) begin
			start_step = full ? hbq_pkg::S_FIN : hbq_pkg::S_I_UP;
		end else begin
			start_step = empty ? hbq_pkg::S_FIN : hbq_pkg::S_E_ROOT;
		end
		upc_d = upc_q;
		if (upc_q == hbq_pkg::S_IDLE) begin
			if (acc) begin
				upc_d = start_step;
			end
		end else if (ctl.fin) begin
			if (fin_go) begin
				upc_d = hbq_pkg::S_IDLE;
			end
		end else begin
			upc_d = taken ? ctl.tgt : ctl.nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q     <= hbq_pkg::S_IDLE;
			cnt_q     <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (acc && req.func == hbq_pkg::FUNC_INSERT && !full) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (act && ctl.dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (fin_go) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			mov_q <= '{key: req.key, payload: req.payload};
			if (req.func == hbq_pkg::FUNC_INSERT) begin
				pos_q    <= cnt_q + CW'(1);
				status_q <= full ? hbq_pkg::ST_FULL : hbq_pkg::ST_OK;
				ext_q    <= 1'b0;
			end else begin
				pos_q    <= CW'(1);
				status_q <= empty ? hbq_pkg::ST_EMPTY : hbq_pkg::ST_OK;
				ext_q    <= !empty;
			end
		end else begin
			if (act && ctl.pos == hbq_pkg::POS_PARENT) begin
				pos_q <= par_idx;
			end else if (act && ctl.pos == hbq_pkg::POS_CHILD) begin
				pos_q <= cidx_q;
			end
			if (ctl.cap == hbq_pkg::CAP_MOV) begin
				mov_q <= rd_ent;
			end
		end
		if (ctl.cap == hbq_pkg::CAP_TOP) begin
			top_q <= rd_ent;
		end
		// keep the smaller child, left on a tie
		if (ctl.cap == hbq_pkg::CAP_LEFT) begin
			child_q <= rd_ent;
			cidx_q  <= CW'(pos2);
		end else if (ctl.cap == hbq_pkg::CAP_RIGHT && child_q.key > rd_ent.key) begin
			child_q <= rd_ent;
			cidx_q  <= CW'(pos2 + (CW+1)'(1));
		end
		if (fin_go) begin
			rsp_q.out_payload <= ext_q ? top_q.payload : '0;
			rsp_q.out_key     <= ext_q ? top_q.key : '0;
			rsp_q.out_valid   <= ext_q;
			rsp_q.status      <= status_q;
			rsp_q.fill_level  <= FW'(cnt_q);
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(re && we))
		else $error("heap RAM read and write in one step");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(upc_q == hbq_pkg::S_FIN))
		else $error("response raised outside the final step");

	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == hbq_pkg::S_I_UP || upc_q == hbq_pkg::S_D_LEFT ||
		 upc_q == hbq_pkg::S_PUT) |-> pos_q != '0)
		else $error("heap position zero during a sift");

	a_ext_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.out_valid) |-> rsp.status == hbq_pkg::ST_OK)
		else $error("returned entry with error status");

endmodule

/* test/binary_min_heap_queue_core_tb.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core_tb
// Drives insert and extract requests into the min-heap queue core, keeps a
// heap of its own that predicts every response, and checks each response
// field by field. Stimulus runs through fill and drain phases, phases with
// tied keys, random stalls on both sides and one long response stall.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core_tb;

	localparam int N_RANDOM        = 1500;
	localparam int LONG_HOLD_AT    = 400;
	localparam int LONG_HOLD_LEN   = 300;
	localparam int STALL_LIMIT     = 5000;
	localparam int SETTLE_CYCLES   = 60;

	typedef struct {
		bit            drain;
		hbq_pkg::req_t item;
	} stim_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	hbq_pkg::req_t  req = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	hbq_pkg::rsp_t  rsp;

	stim_t           req_backlog[$];
	hbq_pkg::rsp_t   due_rsp[$];
	hbq_pkg::entry_t model_heap[1:hbq_pkg::HEAP_CAPACITY];
	int     model_cnt = 0;
	int     sent_cnt = 0;
	int     got_cnt = 0;
	int     err_cnt = 0;
	int     tx_gap = 0;
	int     rx_hold = 0;
	int     idle_cycles = 0;
	bit     tx_burst = 1'b0;
	bit     rx_burst = 1'b0;
	bit     offering;
	stim_t  head;

	binary_min_heap_queue_core #(.CAPACITY(hbq_pkg::HEAP_CAPACITY)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Apply one request to the shadow heap and return the response it causes.
	function automatic hbq_pkg::rsp_t heap_apply(input hbq_pkg::req_t r);
		hbq_pkg::rsp_t   o;
		hbq_pkg::entry_t top;
		hbq_pkg::entry_t moving;
		int     pos;
		int     child;
		bit     sinking;
		o = '0;
		if (r.func == hbq_pkg::FUNC_INSERT) begin
			if (model_cnt >= hbq_pkg::HEAP_CAPACITY) begin
				o.status = hbq_pkg::ST_FULL;
			end else begin
				model_cnt++;
				pos = model_cnt;
				while (pos > 1 && model_heap[pos / 2].key > r.key) begin
					model_heap[pos] = model_heap[pos / 2];
					pos = pos / 2;
				end
				model_heap[pos].key = r.key;
				model_heap[pos].payload = r.payload;
				o.status = hbq_pkg::ST_OK;
			end
		end else if (model_cnt == 0) begin
			o.status = hbq_pkg::ST_EMPTY;
		end else begin
			top = model_heap[1];
			moving = model_heap[model_cnt];
			model_cnt--;
			pos = 1;
			sinking = 1'b1;
			while (sinking && pos * 2 <= model_cnt) begin
				child = pos * 2;
				// left child wins a tie
				if (child != model_cnt && model_heap[child].key > model_heap[child + 1].key)
					child++;
				if (moving.key > model_heap[child].key) begin
					model_heap[pos] = model_heap[child];
					pos = child;
				end else begin
					sinking = 1'b0;
				end
			end
			model_heap[pos] = moving;
			o.out_key = top.key;
			o.out_payload = top.payload;
			o.out_valid = 1'b1;
			o.status = hbq_pkg::ST_OK;
		end
		o.fill_level = model_cnt[hbq_pkg::FILL_W-1:0];
		return o;
	endfunction

	function automatic int draw_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, 6);
	endfunction

	task automatic push_req(input logic f, input logic [hbq_pkg::KEY_W-1:0] k,
		input logic [hbq_pkg::PAY_W-1:0] p);
		stim_t s;
		s.drain = 1'b0;
		s.item.func = f;
		s.item.key = k;
		s.item.payload = p;
		req_backlog.push_back(s);
	endtask

	task automatic push_drain();
		stim_t s;
		s.drain = 1'b1;
		s.item = '0;
		req_backlog.push_back(s);
	endtask

	function automatic logic [hbq_pkg::KEY_W-1:0] pick_key(input int mode);
		case (mode)
			0: return hbq_pkg::KEY_W'($urandom_range(0, 7));
			1: return $urandom_range(0, 1)
				? {hbq_pkg::KEY_W{1'b1}} - hbq_pkg::KEY_W'($urandom_range(0, 2))
				: hbq_pkg::KEY_W'($urandom_range(0, 2));
			default: return hbq_pkg::KEY_W'($urandom());
		endcase
	endfunction

	task automatic build_stimulus();
		int total;
		int kind;
		int len;
		int pct;
		int kmode;
		// extract on empty, extremes, and equal keys
		push_req(hbq_pkg::FUNC_EXTRACT, 16'h0000, 16'h0000);
		push_req(hbq_pkg::FUNC_INSERT, 16'hFFFF, 16'h0000);
		push_req(hbq_pkg::FUNC_INSERT, 16'h0000, 16'hFFFF);
		push_req(hbq_pkg::FUNC_INSERT, 16'h8000, 16'h1234);
		push_req(hbq_pkg::FUNC_INSERT, 16'h0005, 16'h0001);
		push_req(hbq_pkg::FUNC_INSERT, 16'h0005, 16'h0002);
		push_req(hbq_pkg::FUNC_INSERT, 16'h0005, 16'h0003);
		push_req(hbq_pkg::FUNC_INSERT, 16'h0004, 16'h5555);
		push_req(hbq_pkg::FUNC_INSERT, 16'h0005, 16'hAAAA);
		repeat (9) push_req(hbq_pkg::FUNC_EXTRACT, 16'hFFFF, 16'hFFFF);
		push_drain();
		total = 0;
		kind = 0;
		while (total < N_RANDOM) begin
			kmode = $urandom_range(0, 2);
			case (kind)
				0: begin
					// overfill to hit the full case
					len = hbq_pkg::HEAP_CAPACITY + $urandom_range(2, 8);
					pct = 100;
				end
				1: begin
					len = hbq_pkg::HEAP_CAPACITY + $urandom_range(2, 8);
					pct = 0;
				end
				default: begin
					len = $urandom_range(20, 120);
					case ($urandom_range(0, 2))
						0: pct = 20;
						1: pct = 50;
						default: pct = 80;
					endcase
				end
			endcase
			repeat (len) begin
				if ($urandom_range(1, 100) <= pct)
					push_req(hbq_pkg::FUNC_INSERT, pick_key(kmode),
						hbq_pkg::PAY_W'($urandom()));
				else
					push_req(hbq_pkg::FUNC_EXTRACT, hbq_pkg::KEY_W'($urandom()),
						hbq_pkg::PAY_W'($urandom()));
			end
			total += len;
			if ($urandom_range(0, 3) == 0)
				push_drain();
			kind = (kind < 2) ? kind + 1 : $urandom_range(0, 5);
		end
	endtask

	// driver: one nonblocking write of req_valid per edge
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			offering = req_valid;
			if (req_valid && req_ready) begin
				due_rsp.push_back(heap_apply(req));
				sent_cnt++;
				offering = 1'b0;
				if ($urandom_range(0, 39) == 0)
					tx_burst = ~tx_burst;
				tx_gap = draw_wait(tx_burst);
			end
			if (!offering) begin
				// hold at a pause marker until every response is back
				if (req_backlog.size() > 0 && req_backlog[0].drain && got_cnt == sent_cnt)
					head = req_backlog.pop_front();
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (req_backlog.size() > 0 && !req_backlog[0].drain) begin
					head = req_backlog.pop_front();
					req <= head.item;
					offering = 1'b1;
				end
			end
			req_valid <= offering;
		end
	end

	// response side: random stalls, one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rx_hold = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if ($urandom_range(0, 39) == 0)
					rx_burst = ~rx_burst;
				rx_hold = (got_cnt == LONG_HOLD_AT) ? LONG_HOLD_LEN : draw_wait(rx_burst);
			end else if (rx_hold > 0) begin
				rx_hold--;
			end
			rsp_ready <= (rx_hold == 0);
		end
	end

	// check at the falling edge a response that the next rising edge accepts
	always @(negedge clk) begin
		hbq_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			got_cnt++;
			if (due_rsp.size() == 0) begin
				$error("unexpected response %h", rsp);
				err_cnt++;
			end else begin
				want = due_rsp.pop_front();
				if (rsp.out_payload !== want.out_payload) begin
					$error("out_payload: expected %h, actual %h", want.out_payload, rsp.out_payload);
					err_cnt++;
				end
				if (rsp.out_key !== want.out_key) begin
					$error("out_key: expected %h, actual %h", want.out_key, rsp.out_key);
					err_cnt++;
				end
				if (rsp.out_valid !== want.out_valid) begin
					$error("out_valid: expected %b, actual %b", want.out_valid, rsp.out_valid);
					err_cnt++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					err_cnt++;
				end
				if (rsp.fill_level !== want.fill_level) begin
					$error("fill_level: expected %0d, actual %0d", want.fill_level,
						rsp.fill_level);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout with %0d responses outstanding", due_rsp.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		build_stimulus();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (req_backlog.size() > 0 || req_valid || got_cnt != sent_cnt)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_rsp.size() != 0) begin
			$error("%0d responses never arrived", due_rsp.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
